@@ design/ccc_pkg.sv @@
// Shared types, constants and reset values for the calibrated colour classifier.
package ccc_pkg;

  // fixed field widths
  localparam int SAMPLE_W   = 10;
  localparam int OP_W       = 2;
  localparam int CH_W       = 2;
  localparam int VAL_W      = 19;
  localparam int CLASS_W    = 3;
  localparam int CFG_W      = 10;
  localparam int CFG_NUM    = 5;
  localparam int CFG_IDX_W  = 3;

  // stream packing
  localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int IN_USER_W  = OP_W + CH_W;
  localparam int OUT_BITS   = CLASS_W + 3 * VAL_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

  // defaults for the top-level parameters
  localparam int SAMPLES_DEF  = 5;
  localparam int ADC_BITS_DEF = 10;

  // scale of 255 is done as (x << 8) - x
  localparam int NORM_SHIFT = 8;

  localparam int VAL_MAX = 262143;
  localparam int VAL_MIN = -262144;

  // threshold register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RED_BRIGHT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_RED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_ORANGE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_BLUE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LOW    = 3'd4;

  localparam int CFG_RST   [CFG_NUM] = '{145, 160, 150, 200, 100};
  localparam int WHITE_RST [3]       = '{22, 25, 22};
  localparam int BLACK_RST [3]       = '{1, 2, 2};
  localparam int SPAN_RST  [3]       = '{21, 23, 20};

  typedef enum logic [OP_W-1:0] {
    OP_MEASURE = 2'd0,
    OP_WHITE   = 2'd1,
    OP_BLACK   = 2'd2
  } op_t;

  typedef enum logic [CH_W-1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  // spare channel code, handled as blue
  localparam logic [CH_W-1:0] CH_SPARE = 2'd3;

  typedef enum logic [CLASS_W-1:0] {
    CLS_RED    = 3'd0,
    CLS_GREEN  = 3'd1,
    CLS_BLUE   = 3'd2,
    CLS_ORANGE = 3'd3,
    CLS_PURPLE = 3'd4,
    CLS_WHITE  = 3'd5
  } class_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_DISPATCH,
    ST_NORM,
    ST_FINISH,
    ST_EMIT
  } state_t;

  // status of a closed sample run
  typedef struct packed {
    logic            done;
    logic [OP_W-1:0] op;
    chan_t           ch;
  } run_t;

endpackage

@@ design/ccc_accum.sv @@
// Run accumulator: sums samples and flags the beat that closes a run.
module ccc_accum #(
  parameter int SAMPLES  = ccc_pkg::SAMPLES_DEF,
  parameter int ADC_BITS = ccc_pkg::ADC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [ccc_pkg::OP_W-1:0]     op,
  input  logic [ccc_pkg::CH_W-1:0]     ch,
  input  logic [ccc_pkg::SAMPLE_W-1:0] sample,
  output ccc_pkg::run_t                run,
  output logic [ADC_BITS+$clog2(SAMPLES+1)-1:0] run_sum
);

  localparam int SUM_W = ADC_BITS + $clog2(SAMPLES + 1);
  localparam int CNT_W = $clog2(SAMPLES + 1);

  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADC_BITS-1:0] smp;
  logic [SUM_W-1:0]    total;
  logic                last;

  assign smp   = ADC_BITS'(sample);
  assign total = sum_r + SUM_W'(smp);
  assign last  = (cnt_r == CNT_W'(SAMPLES - 1));

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (last) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = total;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // channel code 3 is handled as blue
  assign run.done = accept && last;
  assign run.op   = op;
  assign run.ch   = (ch == ccc_pkg::CH_SPARE) ? ccc_pkg::CH_BLUE : ccc_pkg::chan_t'(ch);
  assign run_sum  = total;

endmodule

@@ design/ccc_serial_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module ccc_serial_div #(
  parameter int NUM_W = ccc_pkg::ADC_BITS_DEF + ccc_pkg::NORM_SHIFT,
  parameter int DEN_W = ccc_pkg::ADC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output logic             done
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = (shifted >= {1'b0, den_r});
  assign rem_nxt = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  assign quo_nxt = {quo_r[NUM_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CW'(1));
      if (start) begin
        cnt_r <= CW'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

@@ design/ccc_classify.sv @@
// Threshold tree that turns three normalized readings into a colour class.
module ccc_classify (
  input  logic signed [ccc_pkg::VAL_W-1:0] red,
  input  logic signed [ccc_pkg::VAL_W-1:0] green,
  input  logic signed [ccc_pkg::VAL_W-1:0] blue,
  input  logic [ccc_pkg::CFG_W-1:0]        thr [ccc_pkg::CFG_NUM],
  output ccc_pkg::class_t                  colour
);

  logic signed [ccc_pkg::VAL_W-1:0] t_red_bright;
  logic signed [ccc_pkg::VAL_W-1:0] t_green_red;
  logic signed [ccc_pkg::VAL_W-1:0] t_blue_orange;
  logic signed [ccc_pkg::VAL_W-1:0] t_green_blue;
  logic signed [ccc_pkg::VAL_W-1:0] t_green_low;

  // thresholds are unsigned, so they widen with zeros
  assign t_red_bright  = $signed(ccc_pkg::VAL_W'(thr[ccc_pkg::CFG_RED_BRIGHT]));
  assign t_green_red   = $signed(ccc_pkg::VAL_W'(thr[ccc_pkg::CFG_GREEN_RED]));
  assign t_blue_orange = $signed(ccc_pkg::VAL_W'(thr[ccc_pkg::CFG_BLUE_ORANGE]));
  assign t_green_blue  = $signed(ccc_pkg::VAL_W'(thr[ccc_pkg::CFG_GREEN_BLUE]));
  assign t_green_low   = $signed(ccc_pkg::VAL_W'(thr[ccc_pkg::CFG_GREEN_LOW]));

  always_comb begin
    if (red > t_red_bright) begin
      if (green < t_green_red) begin
        colour = ccc_pkg::CLS_RED;
      end else if (blue < t_blue_orange) begin
        colour = ccc_pkg::CLS_ORANGE;
      end else begin
        colour = ccc_pkg::CLS_WHITE;
      end
    end else if (green > t_green_blue) begin
      colour = ccc_pkg::CLS_BLUE;
    end else if (green > t_green_low) begin
      colour = ccc_pkg::CLS_GREEN;
    end else begin
      colour = ccc_pkg::CLS_PURPLE;
    end
  end

endmodule

@@ design/calibrated_colour_classifier_unit.sv @@
// Top level: calibration store, normalization sequencer and result register.
// Each sample beat tagged with an operation (in_tuser[1:0]) and a channel (in_tuser[3:2]) adds
// to a running sum; every SAMPLES-th beat closes the run. A white or black capture run updates
// that channel's calibration, a measure run stores (avg - black) * 255 / span, and the blue
// measure run emits the class and all three values as one out beat, with out_tuser flagging a
// zero span on any channel. A beat that does not close a run leaves in_tready high. A closing
// beat keeps in_tready low while the shared one-bit-per-cycle divider works: one pass for a
// capture or discarded run and for a red or green measure run on a zero span, and two for a
// red or green measure run, one divider pass for the average and one for the normalization.
// The blue measure run also loads the result in the emit step, and stalls longer while an
// earlier result still waits in the output register. A waiting result in the output register
// does not hold off samples until the next blue result is ready.
module calibrated_colour_classifier_unit #(
  parameter int SAMPLES  = ccc_pkg::SAMPLES_DEF,
  parameter int ADC_BITS = ccc_pkg::ADC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: sample[9:0]
  input  logic [ccc_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: operation[1:0], channel[3:2]
  input  logic [ccc_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // out_tdata: colour_class[2:0], red_value[21:3], green_value[40:22], blue_value[59:41]
  output logic [ccc_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: span_error[0]
  output logic                             out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [ccc_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [ccc_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int A      = ADC_BITS;
  localparam int LVL_W  = A + 1;
  localparam int SUM_W  = A + $clog2(SAMPLES + 1);
  localparam int NUM_W  = A + ccc_pkg::NORM_SHIFT;
  localparam int PROD_W = NUM_W + 1;
  localparam int QW     = NUM_W + 1;
  localparam int SAT_W  = (QW > ccc_pkg::VAL_W) ? QW : ccc_pkg::VAL_W;
  localparam int VW     = ccc_pkg::VAL_W;

  ccc_pkg::state_t state_r, state_nxt;

  ccc_pkg::run_t           run;
  logic [SUM_W-1:0]        run_sum;
  logic                    in_accept;

  logic [ccc_pkg::OP_W-1:0] op_r;
  ccc_pkg::chan_t           ch_r;
  logic                     neg_r;
  logic                     zero_r;

  logic [A-1:0]            white_r [3];
  logic [A-1:0]            black_r [3];
  logic signed [LVL_W-1:0] span_r  [3];
  logic signed [VW-1:0]    meas_r  [2];
  logic                    merr_r  [2];
  logic signed [VW-1:0]    blue_r;
  logic                    berr_r;
  logic [ccc_pkg::CFG_W-1:0] cfg_r [ccc_pkg::CFG_NUM];

  logic                    out_valid_r;
  ccc_pkg::class_t         out_class_r;
  logic [VW-1:0]           out_red_r, out_green_r, out_blue_r;
  logic                    out_err_r;

  // divider hookup
  logic                    div_start;
  logic [NUM_W-1:0]        div_num;
  logic [A-1:0]            div_den;
  logic [NUM_W-1:0]        div_quo;
  logic                    div_done;

  // datapath around the run result
  logic [A-1:0]             avg;
  logic signed [LVL_W-1:0]  span_cur;
  logic signed [LVL_W-1:0]  new_span;
  logic signed [LVL_W-1:0]  diff;
  logic signed [PROD_W-1:0] diff_x, prod, prod_abs;
  logic [NUM_W-1:0]         num_mag;
  logic signed [LVL_W-1:0]  span_abs;
  logic [A-1:0]             den_mag;
  logic                     span_zero;
  logic signed [QW-1:0]     quo_s, q_signed;
  logic signed [SAT_W-1:0]  q_x;
  logic signed [VW-1:0]     value;
  ccc_pkg::class_t          cls;

  logic                     out_load;
  logic                     norm_start;

  assign in_accept = in_tvalid && in_tready;

  ccc_accum #(
    .SAMPLES  (SAMPLES),
    .ADC_BITS (ADC_BITS)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .op      (in_tuser[ccc_pkg::OP_W-1:0]),
    .ch      (in_tuser[ccc_pkg::IN_USER_W-1:ccc_pkg::OP_W]),
    .sample  (in_tdata[ccc_pkg::SAMPLE_W-1:0]),
    .run     (run),
    .run_sum (run_sum)
  );

  ccc_serial_div #(
    .NUM_W (NUM_W),
    .DEN_W (A)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_quo),
    .done     (div_done)
  );

  ccc_classify u_classify (
    .red    (meas_r[0]),
    .green  (meas_r[1]),
    .blue   (blue_r),
    .thr    (cfg_r),
    .colour (cls)
  );

  // average and normalization operands
  assign avg       = div_quo[A-1:0];
  assign span_cur  = span_r[ch_r];
  assign span_zero = (span_cur == '0);
  assign new_span  = $signed({1'b0, white_r[ch_r]}) - $signed({1'b0, avg});
  assign diff      = $signed({1'b0, avg}) - $signed({1'b0, black_r[ch_r]});
  assign diff_x    = PROD_W'(diff);
  assign prod      = (diff_x <<< ccc_pkg::NORM_SHIFT) - diff_x;
  assign prod_abs  = prod[PROD_W-1] ? -prod : prod;
  assign num_mag   = prod_abs[NUM_W-1:0];
  assign span_abs  = span_cur[LVL_W-1] ? -span_cur : span_cur;
  assign den_mag   = span_abs[A-1:0];

  // signed quotient, truncated toward zero, then clamped to the value range
  assign quo_s    = $signed({1'b0, div_quo});
  assign q_signed = neg_r ? -quo_s : quo_s;
  assign q_x      = SAT_W'(q_signed);

  always_comb begin
    if (zero_r) begin
      value = '0;
    end else if (q_x > SAT_W'(ccc_pkg::VAL_MAX)) begin
      value = VW'(ccc_pkg::VAL_MAX);
    end else if (q_x < SAT_W'(ccc_pkg::VAL_MIN)) begin
      value = VW'(ccc_pkg::VAL_MIN);
    end else begin
      value = q_x[VW-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccc_pkg::ST_IDLE: begin
        if (run.done) state_nxt = ccc_pkg::ST_AVG;
      end
      ccc_pkg::ST_AVG: begin
        if (div_done) state_nxt = ccc_pkg::ST_DISPATCH;
      end
      ccc_pkg::ST_DISPATCH: begin
        if (op_r == ccc_pkg::OP_MEASURE) begin
          state_nxt = span_zero ? ccc_pkg::ST_FINISH : ccc_pkg::ST_NORM;
        end else begin
          state_nxt = ccc_pkg::ST_IDLE;
        end
      end
      ccc_pkg::ST_NORM: begin
        if (div_done) state_nxt = ccc_pkg::ST_FINISH;
      end
      ccc_pkg::ST_FINISH: begin
        state_nxt = (ch_r == ccc_pkg::CH_BLUE) ? ccc_pkg::ST_EMIT : ccc_pkg::ST_IDLE;
      end
      ccc_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) state_nxt = ccc_pkg::ST_IDLE;
      end
      default: state_nxt = ccc_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready  = 1'b0;
    norm_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ccc_pkg::ST_IDLE:     in_tready  = 1'b1;
      ccc_pkg::ST_DISPATCH: norm_start = (op_r == ccc_pkg::OP_MEASURE) && !span_zero;
      ccc_pkg::ST_EMIT:     out_load   = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign div_start = run.done || norm_start;
  assign div_num   = norm_start ? num_mag : NUM_W'(run_sum);
  assign div_den   = norm_start ? den_mag : A'(SAMPLES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // run tag and sign bookkeeping
  always_ff @(posedge clk) begin
    if (run.done) begin
      op_r <= run.op;
      ch_r <= run.ch;
    end
    if (state_r == ccc_pkg::ST_DISPATCH) begin
      neg_r  <= prod[PROD_W-1] ^ span_cur[LVL_W-1];
      zero_r <= span_zero;
    end
  end

  // calibration, stored readings and thresholds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        white_r[i] <= A'(ccc_pkg::WHITE_RST[i]);
        black_r[i] <= A'(ccc_pkg::BLACK_RST[i]);
        span_r[i]  <= LVL_W'(ccc_pkg::SPAN_RST[i]);
      end
      for (int i = 0; i < 2; i++) begin
        meas_r[i] <= '0;
        merr_r[i] <= 1'b0;
      end
      for (int i = 0; i < ccc_pkg::CFG_NUM; i++) begin
        cfg_r[i] <= ccc_pkg::CFG_W'(ccc_pkg::CFG_RST[i]);
      end
    end else begin
      if (state_r == ccc_pkg::ST_DISPATCH) begin
        case (op_r)
          ccc_pkg::OP_WHITE: white_r[ch_r] <= avg;
          ccc_pkg::OP_BLACK: begin
            black_r[ch_r] <= avg;
            span_r[ch_r]  <= new_span;
          end
          default: ;
        endcase
      end
      if (state_r == ccc_pkg::ST_FINISH && ch_r != ccc_pkg::CH_BLUE) begin
        meas_r[ch_r[0]] <= value;
        merr_r[ch_r[0]] <= zero_r;
      end
      if (cfg_we) begin
        case (cfg_addr)
          ccc_pkg::CFG_RED_BRIGHT:  cfg_r[0] <= cfg_wdata;
          ccc_pkg::CFG_GREEN_RED:   cfg_r[1] <= cfg_wdata;
          ccc_pkg::CFG_BLUE_ORANGE: cfg_r[2] <= cfg_wdata;
          ccc_pkg::CFG_GREEN_BLUE:  cfg_r[3] <= cfg_wdata;
          ccc_pkg::CFG_GREEN_LOW:   cfg_r[4] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ccc_pkg::ST_FINISH && ch_r == ccc_pkg::CH_BLUE) begin
      blue_r <= value;
      berr_r <= zero_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_class_r <= cls;
      out_red_r   <= meas_r[0];
      out_green_r <= meas_r[1];
      out_blue_r  <= blue_r;
      out_err_r   <= merr_r[0] || merr_r[1] || berr_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_err_r;
  assign out_tdata  = {{ccc_pkg::OUT_PAD_W{1'b0}}, out_blue_r, out_green_r, out_red_r,
                       out_class_r};

  // the divider only finishes while a run is being worked on
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ccc_pkg::ST_IDLE |-> !div_done)
    else $error("divider finished with no run in progress");

  // a closing beat always starts the averaging pass
  assert property (@(posedge clk) disable iff (!rst_n)
    run.done |=> state_r == ccc_pkg::ST_AVG)
    else $error("closed run did not start averaging");

  // a new result only comes from the emit step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ccc_pkg::ST_EMIT)
    else $error("result appeared outside the emit step");

endmodule

@@ dv/testbench.sv @@
// Self-checking stream testbench for the calibrated colour classifier unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLES    = ccc_pkg::SAMPLES_DEF;
  localparam int SMP_MAX    = (1 << ccc_pkg::SAMPLE_W) - 1;
  localparam int FULL_SCALE = 255;
  localparam int SETTLE     = 100;
  localparam int CALM_FROM  = 3000;
  localparam int CALM_TO    = 6000;

  // operation value outside the named enum
  localparam logic [ccc_pkg::OP_W-1:0] OP_DISCARD = 2'd3;

  typedef struct packed {
    logic [ccc_pkg::OP_W-1:0]     op;
    logic [ccc_pkg::CH_W-1:0]     ch;
    logic [ccc_pkg::SAMPLE_W-1:0] sample;
  } beat_t;

  typedef struct {
    ccc_pkg::class_t cls;
    int              red;
    int              green;
    int              blue;
    bit              span_err;
  } reading_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic [ccc_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [ccc_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [ccc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [ccc_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [ccc_pkg::CFG_W-1:0]      cfg_wdata = '0;

  calibrated_colour_classifier_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sensor model state
  logic [ccc_pkg::CFG_W-1:0] thr [ccc_pkg::CFG_NUM];
  int sum_acc;
  int beats_in_run;
  int meas_val [2];
  bit meas_err [2];
  int white_lvl [3];
  int black_lvl [3];
  int span_lvl [3];

  beat_t    beat_q [$];
  reading_t reading_q [$];
  beat_t    cur_beat;
  int       queued;
  int       accepted;
  int       mismatches;
  int unsigned cyc;

  function automatic int normalize_level(int avg, int ch, output bit zero_span);
    int q;
    zero_span = (span_lvl[ch] == 0);
    if (zero_span) return 0;
    // SV int division truncates toward zero, as does the block
    q = ((avg - black_lvl[ch]) * FULL_SCALE) / span_lvl[ch];
    if (q > ccc_pkg::VAL_MAX) q = ccc_pkg::VAL_MAX;
    if (q < ccc_pkg::VAL_MIN) q = ccc_pkg::VAL_MIN;
    return q;
  endfunction

  function automatic ccc_pkg::class_t classify_reading(int r, int g, int b);
    if (r > int'(thr[ccc_pkg::CFG_RED_BRIGHT])) begin
      if (g < int'(thr[ccc_pkg::CFG_GREEN_RED])) return ccc_pkg::CLS_RED;
      if (b < int'(thr[ccc_pkg::CFG_BLUE_ORANGE])) return ccc_pkg::CLS_ORANGE;
      return ccc_pkg::CLS_WHITE;
    end
    if (g > int'(thr[ccc_pkg::CFG_GREEN_BLUE])) return ccc_pkg::CLS_BLUE;
    if (g > int'(thr[ccc_pkg::CFG_GREEN_LOW])) return ccc_pkg::CLS_GREEN;
    return ccc_pkg::CLS_PURPLE;
  endfunction

  function automatic void predict_beat(beat_t b);
    int avg;
    int lvl;
    int ch;
    bit err;
    reading_t r;
    ch = (b.ch == ccc_pkg::CH_SPARE) ? int'(ccc_pkg::CH_BLUE) : int'(b.ch);
    sum_acc += b.sample;
    beats_in_run++;
    if (beats_in_run < SAMPLES) return;
    avg = sum_acc / SAMPLES;
    sum_acc = 0;
    beats_in_run = 0;
    // tags of the closing beat decide what the run does
    case (b.op)
      ccc_pkg::OP_WHITE: white_lvl[ch] = avg;
      ccc_pkg::OP_BLACK: begin
        black_lvl[ch] = avg;
        span_lvl[ch] = white_lvl[ch] - avg;
      end
      ccc_pkg::OP_MEASURE: begin
        lvl = normalize_level(avg, ch, err);
        if (ch != int'(ccc_pkg::CH_BLUE)) begin
          meas_val[ch] = lvl;
          meas_err[ch] = err;
        end else begin
          r.cls = classify_reading(meas_val[ccc_pkg::CH_RED], meas_val[ccc_pkg::CH_GREEN],
                                   lvl);
          r.red = meas_val[ccc_pkg::CH_RED];
          r.green = meas_val[ccc_pkg::CH_GREEN];
          r.blue = lvl;
          r.span_err = meas_err[ccc_pkg::CH_RED] || meas_err[ccc_pkg::CH_GREEN] || err;
          reading_q.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic bit idle_roll();
    return !(cyc >= CALM_FROM && cyc < CALM_TO) && ($urandom_range(99) < 29);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // sample driver
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_beat(cur_beat);
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (beat_q.size() != 0 && !idle_roll()) begin
          cur_beat = beat_q.pop_front();
          in_tdata <= {{(ccc_pkg::IN_DATA_W - ccc_pkg::SAMPLE_W){1'b0}}, cur_beat.sample};
          in_tuser <= {cur_beat.ch, cur_beat.op};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    reading_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (reading_q.size() == 0) begin
          $error("out beat with no reading pending");
          mismatches++;
        end else begin
          want = reading_q.pop_front();
          check_field("colour_class", want.cls, out_tdata[ccc_pkg::CLASS_W-1:0]);
          check_field("red_value", want.red,
                      $signed(out_tdata[ccc_pkg::CLASS_W +: ccc_pkg::VAL_W]));
          check_field("green_value", want.green,
                      $signed(out_tdata[ccc_pkg::CLASS_W + ccc_pkg::VAL_W +: ccc_pkg::VAL_W]));
          check_field("blue_value", want.blue,
                      $signed(out_tdata[ccc_pkg::CLASS_W + 2 * ccc_pkg::VAL_W +:
                                        ccc_pkg::VAL_W]));
          check_field("span_error", want.span_err, out_tuser);
        end
      end
      out_tready <= !idle_roll();
    end
  end

  task automatic add_beat(logic [ccc_pkg::OP_W-1:0] op, logic [ccc_pkg::CH_W-1:0] ch,
                          int smp);
    beat_t b;
    b.op = op;
    b.ch = ch;
    b.sample = smp[ccc_pkg::SAMPLE_W-1:0];
    beat_q.push_back(b);
    queued++;
  endtask

  task automatic add_run(logic [ccc_pkg::OP_W-1:0] op, logic [ccc_pkg::CH_W-1:0] ch,
                         int lo, int hi);
    repeat (SAMPLES) add_beat(op, ch, $urandom_range(hi, lo));
  endtask

  task automatic add_level_run(logic [ccc_pkg::OP_W-1:0] op, logic [ccc_pkg::CH_W-1:0] ch,
                               int level, int spread);
    int lo;
    int hi;
    lo = (level - spread < 0) ? 0 : level - spread;
    hi = (level + spread > SMP_MAX) ? SMP_MAX : level + spread;
    add_run(op, ch, lo, hi);
  endtask

  task automatic write_thr(logic [ccc_pkg::CFG_IDX_W-1:0] idx,
                           logic [ccc_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    thr[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all beats taken, all readings out, and the divider given time to finish
  task automatic wait_idle();
    while (accepted != queued || reading_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_random(int n);
    int start;
    int kind;
    int mode;
    int skip;
    int spread;
    int w;
    int k;
    logic [ccc_pkg::CH_W-1:0] ch;
    start = queued;
    while (queued - start < n) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        // measurement: red, green, blue; sometimes a channel is missing
        skip = $urandom_range(9);
        for (int c = 0; c < 3; c++) begin
          if ((skip == 0 && c == int'(ccc_pkg::CH_RED)) ||
              (skip == 1 && c == int'(ccc_pkg::CH_GREEN))) continue;
          spread = ($urandom_range(7) == 0) ? SMP_MAX : $urandom_range(25);
          ch = (c == int'(ccc_pkg::CH_BLUE) && $urandom_range(3) == 0) ?
               ccc_pkg::CH_SPARE : ccc_pkg::CH_W'(c);
          add_level_run(ccc_pkg::OP_MEASURE, ch, $urandom_range(SMP_MAX), spread);
        end
      end else if (kind < 70) begin
        // calibration of one channel
        ch = ccc_pkg::CH_W'($urandom_range(3));
        mode = $urandom_range(99);
        if (mode < 65) begin
          w = $urandom_range(SMP_MAX, 600);
          k = $urandom_range(250);
          spread = $urandom_range(10);
        end else if (mode < 80) begin
          w = $urandom_range(SMP_MAX);
          k = w;
          spread = 0;
        end else begin
          w = $urandom_range(SMP_MAX);
          k = $urandom_range(SMP_MAX);
          spread = $urandom_range(10);
        end
        if ($urandom_range(9) != 0) add_level_run(ccc_pkg::OP_WHITE, ch, w, spread);
        add_level_run(ccc_pkg::OP_BLACK, ch, k, spread);
      end else if (kind < 85) begin
        add_run(ccc_pkg::OP_W'($urandom_range(3)), ccc_pkg::CH_W'($urandom_range(3)),
                0, SMP_MAX);
      end else begin
        repeat (SAMPLES)
          add_beat(ccc_pkg::OP_W'($urandom_range(3)), ccc_pkg::CH_W'($urandom_range(3)),
                   $urandom_range(SMP_MAX));
      end
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < ccc_pkg::CFG_NUM; i++) thr[i] = ccc_pkg::CFG_RST[i];
    for (int i = 0; i < 3; i++) begin
      white_lvl[i] = ccc_pkg::WHITE_RST[i];
      black_lvl[i] = ccc_pkg::BLACK_RST[i];
      span_lvl[i] = ccc_pkg::SPAN_RST[i];
    end
    for (int i = 0; i < 2; i++) begin
      meas_val[i] = 0;
      meas_err[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // blue white level to zero through the spare channel code
    add_run(ccc_pkg::OP_WHITE, ccc_pkg::CH_SPARE, 0, 0);
    // run closed by the spare operation is dropped
    repeat (SAMPLES - 1) add_beat(ccc_pkg::OP_BLACK, ccc_pkg::CH_BLUE, SMP_MAX);
    add_beat(OP_DISCARD, ccc_pkg::CH_BLUE, SMP_MAX);
    // black equal to white: zero span on blue
    add_run(ccc_pkg::OP_BLACK, ccc_pkg::CH_BLUE, 0, 0);
    // measure red and green on reset calibration, full scale and zero
    add_run(ccc_pkg::OP_MEASURE, ccc_pkg::CH_RED, SMP_MAX, SMP_MAX);
    add_run(ccc_pkg::OP_MEASURE, ccc_pkg::CH_GREEN, 0, 0);
    // mixed tags, closing beat is a measure on the spare channel code
    add_beat(ccc_pkg::OP_WHITE, ccc_pkg::CH_RED, 0);
    add_beat(ccc_pkg::OP_BLACK, ccc_pkg::CH_GREEN, SMP_MAX);
    add_beat(OP_DISCARD, ccc_pkg::CH_SPARE, 512);
    add_beat(ccc_pkg::OP_WHITE, ccc_pkg::CH_BLUE, 341);
    add_beat(ccc_pkg::OP_MEASURE, ccc_pkg::CH_SPARE, 682);
    add_random(160);
    wait_idle();

    for (int p = 1; p <= 6; p++) begin
      for (int i = 0; i < ccc_pkg::CFG_NUM; i++) begin
        if (p == 1) write_thr(ccc_pkg::CFG_IDX_W'(i), '0);
        else if (p == 2) write_thr(ccc_pkg::CFG_IDX_W'(i), '1);
        else begin
          case ($urandom_range(9))
            0: write_thr(ccc_pkg::CFG_IDX_W'(i), '0);
            1: write_thr(ccc_pkg::CFG_IDX_W'(i), '1);
            default: write_thr(ccc_pkg::CFG_IDX_W'(i), ccc_pkg::CFG_W'($urandom_range(300)));
          endcase
        end
      end
      add_random(185);
      wait_idle();
    end

    if (mismatches == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

@@ calibrated_colour_classifier_unit.f @@
design/ccc_pkg.sv
design/ccc_accum.sv
design/ccc_serial_div.sv
design/ccc_classify.sv
design/calibrated_colour_classifier_unit.sv
dv/testbench.sv
